// File: design/u8d_pkg.sv
package u8d_pkg;

    localparam int unsigned MAX_SEQ_BYTES = 6;
    localparam int unsigned PEND_DEPTH    = 5;
    localparam int unsigned CP_W          = 31;
    localparam int unsigned Q_DEPTH       = 2;
    localparam int unsigned Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W       = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] PAYLOAD6  = 8'h3F;
    localparam logic [7:0] ASCII_MAX = 8'h7F;

    // One queued job for the result side: cnt results, the first cnt-1 taken
    // from pend, the final one from value.
    typedef struct packed {
        logic [2:0]                  cnt;
        logic                        raw;
        logic [CP_W-1:0]             value;
        logic [PEND_DEPTH-1:0][7:0]  pend;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Sequence length from the count of leading ones of a lead byte.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd7;
        casez (b)
            8'b110?????: n = 3'd2;
            8'b1110????: n = 3'd3;
            8'b11110???: n = 3'd4;
            8'b111110??: n = 3'd5;
            8'b1111110?: n = 3'd6;
            default:     n = 3'd7;
        endcase
        return n;
    endfunction

endpackage

// File: design/u8d_front.sv
module u8d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wen,
    input  logic           i_cfg_wdata,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_start,
    input  logic           i_end,
    input  u8d_pkg::t_qstat i_qstat,
    output logic           o_push,
    output u8d_pkg::t_cmd  o_cmd
);
    import u8d_pkg::*;

    logic                       r_start_utf8;
    logic                       r_mode, n_mode;
    logic [2:0]                 r_exp, n_exp;
    logic [2:0]                 r_seen, n_seen;
    logic [CP_W-1:0]            r_part, n_part;
    logic [PEND_DEPTH-1:0][7:0] r_pend, n_pend;

    logic            accept;
    logic            mode_e;
    logic [2:0]      seen_e;
    logic [2:0]      exp_e;
    logic [CP_W-1:0] part_e;
    logic [CP_W-1:0] pv;
    logic [2:0]      len;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    // A string start applies before the byte is looked at.
    assign mode_e = i_start ? r_start_utf8 : r_mode;
    assign seen_e = i_start ? 3'd0 : r_seen;
    assign exp_e  = i_start ? 3'd0 : r_exp;
    assign part_e = i_start ? '0 : r_part;
    assign pv     = {part_e[CP_W-7:0], i_byte[5:0] & PAYLOAD6[5:0]};
    assign len    = lead_len(i_byte);

    always_comb begin
        n_mode = r_mode;
        n_exp  = r_exp;
        n_seen = r_seen;
        n_part = r_part;
        n_pend = r_pend;
        o_push = 1'b0;
        o_cmd  = '0;
        if (accept) begin
            n_mode = mode_e;
            n_exp  = exp_e;
            n_seen = seen_e;
            n_part = part_e;
            o_cmd.pend  = r_pend;
            o_cmd.value = {{(CP_W-8){1'b0}}, i_byte};
            o_cmd.cnt   = 3'd1;
            if (!mode_e) begin
                o_push    = 1'b1;
                o_cmd.raw = 1'b1;
                n_exp     = 3'd0;
                n_seen    = 3'd0;
                n_part    = '0;
            end else if (seen_e == 3'd0) begin
                if (i_byte <= ASCII_MAX) begin
                    o_push = 1'b1;
                end else if ((i_byte & CONT_MASK) == CONT_TAG || len > 3'(MAX_SEQ_BYTES)
                             || i_end) begin
                    // invalid lead, too long, or cut off: give the byte raw
                    o_push    = 1'b1;
                    o_cmd.raw = 1'b1;
                    n_mode    = 1'b0;
                end else begin
                    n_pend[0] = i_byte;
                    n_seen    = 3'd1;
                    n_exp     = len;
                    n_part    = {{(CP_W-8){1'b0}}, i_byte & (ASCII_MAX >> len)};
                end
            end else begin
                if ((i_byte & CONT_MASK) != CONT_TAG
                    || ((seen_e + 3'd1 >= exp_e) && pv <= CP_W'(ASCII_MAX))
                    || ((seen_e + 3'd1 < exp_e) && (i_end || seen_e >= 3'(PEND_DEPTH)))) begin
                    // flush buffered bytes and this one, all raw
                    o_push    = 1'b1;
                    o_cmd.raw = 1'b1;
                    o_cmd.cnt = seen_e + 3'd1;
                    n_mode    = 1'b0;
                    n_exp     = 3'd0;
                    n_seen    = 3'd0;
                    n_part    = '0;
                end else if (seen_e + 3'd1 >= exp_e) begin
                    o_push      = 1'b1;
                    o_cmd.value = pv;
                    n_exp       = 3'd0;
                    n_seen      = 3'd0;
                    n_part      = '0;
                end else begin
                    n_pend[seen_e] = i_byte;
                    n_seen         = seen_e + 3'd1;
                    n_part         = pv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_utf8 <= 1'b1;
            r_mode       <= 1'b1;
            r_exp        <= 3'd0;
            r_seen       <= 3'd0;
            r_part       <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_start_utf8 <= i_cfg_wdata;
            end
            r_mode <= n_mode;
            r_exp  <= n_exp;
            r_seen <= n_seen;
            r_part <= n_part;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

// File: design/u8d_queue.sv
module u8d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8d_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output u8d_pkg::t_cmd   o_head,
    output u8d_pkg::t_qstat o_stat
);
    import u8d_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, n_wp;
    logic [Q_PTR_W-1:0] r_rp, n_rp;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// File: design/u8d_back.sv
module u8d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u8d_pkg::t_cmd   i_head,
    input  u8d_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_data,
    output logic            o_raw,
    output logic            o_last
);
    import u8d_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       xfer;

    assign o_valid = !i_qstat.empty;
    assign o_last  = (r_idx == i_head.cnt - 3'd1);
    assign o_raw   = i_head.raw;
    assign o_data  = o_last ? {1'b0, i_head.value}
                            : {24'd0, i_head.pend[r_idx]};
    assign xfer    = o_valid && i_ready;
    assign o_pop   = xfer && o_last;

    // step through the buffered bytes; restart at the next job
    always_comb begin
        n_idx = r_idx;
        if (xfer) begin
            n_idx = o_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

// File: design/utf8_decoder_raw_fallback_core.sv
// Channel   Dir  tdata                  tlast        tuser
// s_axis    in   [7:0] data_byte        string_end   string_start
// m_axis    out  [30:0] code_point      last_of_run  was_raw
// cfg       in   i_cfg_wdata = start_in_utf8, written when i_cfg_wen is high
//
// One byte per cycle is accepted while the job queue is not full. A byte gives at most
// one result, except a raw flush, which gives one result per buffered byte plus the
// current byte (up to 6 results for that byte). A two-entry job queue between the decoder
// and the output side absorbs these bursts; s_axis_tready drops only when it is full.
// Synchronous active-low reset clears mode, sequence state and the queue.
module utf8_decoder_raw_fallback_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] string_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] code_point, [31] zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] was_raw
);
    import u8d_pkg::*;

    t_cmd   push_cmd;
    t_cmd   head;
    t_qstat qstat;
    logic   push;
    logic   pop;

    u8d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_start     (s_axis_tuser),
        .i_end       (s_axis_tlast),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    u8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_raw   (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // decoded characters always come alone
    a_cooked_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("decoded result not marked last");

    // only a raw flush spreads over several results
    a_multi_is_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
        else $error("non-final result not raw");

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("queue not empty after reset");
`endif

endmodule

// File: tb/utf8_decoder_raw_fallback_core_tb.sv
module utf8_decoder_raw_fallback_core_tb;
    import u8d_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned IDLE_PCT     = 16;
    localparam logic [7:0]  INVALID_LEAD = 8'hFE;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            was_raw;
        logic            last_of_run;
    } t_cp_item;

    // Tracks decoder state and the code points still owed by the block.
    class t_decode_tracker;
        bit              start_utf8;
        bit              utf_mode;
        int unsigned     seq_len;
        int unsigned     seq_seen;
        logic [7:0]      held[PEND_DEPTH];
        logic [CP_W-1:0] acc;
        t_cp_item        cp_queue[$];
        int unsigned     errors;

        function new();
            start_utf8 = 1'b1;
            utf_mode   = 1'b1;
            errors     = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            seq_len  = 0;
            seq_seen = 0;
            acc      = '0;
        endfunction

        function void push_cp(logic [CP_W-1:0] cp, bit raw, bit last);
            t_cp_item item;
            item.code_point  = cp;
            item.was_raw     = raw;
            item.last_of_run = last;
            cp_queue.push_back(item);
        endfunction

        // Drop to raw: replay buffered bytes, then the current one.
        function void fall_back(logic [7:0] cur);
            int unsigned cnt;
            cnt = (seq_seen > PEND_DEPTH) ? PEND_DEPTH : seq_seen;
            for (int unsigned i = 0; i < cnt; i++) begin
                push_cp(CP_W'(held[i]), 1'b1, 1'b0);
            end
            push_cp(CP_W'(cur), 1'b1, 1'b1);
            utf_mode = 1'b0;
            clear_seq();
        endfunction

        function void note_byte(logic [7:0] b, bit st, bit en);
            int unsigned n;
            if (st) begin
                utf_mode = start_utf8;
                clear_seq();
            end
            if (!utf_mode) begin
                clear_seq();
                push_cp(CP_W'(b), 1'b1, 1'b1);
            end else if (seq_seen == 0) begin
                if (b <= ASCII_MAX) begin
                    push_cp(CP_W'(b), 1'b0, 1'b1);
                end else if ((b & CONT_MASK) == CONT_TAG ||
                             (b & INVALID_LEAD) == INVALID_LEAD) begin
                    fall_back(b);
                end else begin
                    n = 1;
                    while (n < 8 && b[7-n]) n++;
                    if (n > MAX_SEQ_BYTES || n > PEND_DEPTH + 1 || en) begin
                        fall_back(b);
                    end else begin
                        held[0]  = b;
                        seq_seen = 1;
                        seq_len  = n;
                        acc      = CP_W'(b & (ASCII_MAX >> n));
                    end
                end
            end else if ((b & CONT_MASK) != CONT_TAG) begin
                fall_back(b);
            end else begin
                acc = (acc << 6) | CP_W'(b & PAYLOAD6);
                if (seq_seen + 1 >= seq_len) begin
                    if (acc <= CP_W'(ASCII_MAX)) begin
                        fall_back(b);
                    end else begin
                        push_cp(acc, 1'b0, 1'b1);
                        clear_seq();
                    end
                end else if (en || seq_seen >= PEND_DEPTH) begin
                    fall_back(b);
                end else begin
                    held[seq_seen] = b;
                    seq_seen++;
                end
            end
        endfunction

        function void check_result(logic [CP_W-1:0] cp, logic raw, logic last);
            t_cp_item want;
            if (cp_queue.size() == 0) begin
                $error("unexpected code point transaction: code_point %h", cp);
                errors++;
                return;
            end
            want = cp_queue.pop_front();
            if (cp !== want.code_point) begin
                $error("code_point: expected %h, got %h", want.code_point, cp);
                errors++;
            end
            if (raw !== want.was_raw) begin
                $error("was_raw: expected %0d, got %0d", want.was_raw, raw);
                errors++;
            end
            if (last !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;
    logic        s_axis_tuser;   // [0] string_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [30:0] code_point, [31] zero
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // [0] was_raw

    t_decode_tracker sb = new();
    bit              calm;
    int unsigned     cycle_count;
    int unsigned     random_items;
    logic [7:0]      str_bytes[$];

    utf8_decoder_raw_fallback_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[CP_W-1:0], m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, bit st, bit en);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        s_axis_tlast  <= en;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, st, en);
    endtask

    task automatic send_string(logic [7:0] text[$], bit with_start, bit with_end);
        for (int i = 0; i < text.size(); i++) begin
            send_byte(text[i], with_start && i == 0, with_end && i == text.size() - 1);
        end
    endtask

    // Hold the stream until every owed code point has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.cp_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_mode(bit v);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        sb.start_utf8 = v;
    endtask

    function automatic void add_lead_and_conts(int unsigned len, int unsigned conts);
        logic [7:0] lead;
        lead = (8'hFF << (8 - len)) | (8'($urandom) & (ASCII_MAX >> len));
        str_bytes.push_back(lead);
        for (int unsigned i = 0; i < conts; i++) begin
            str_bytes.push_back(CONT_TAG | (8'($urandom) & PAYLOAD6));
        end
    endfunction

    function automatic void add_char(int unsigned len, logic [CP_W-1:0] cp);
        if (len == 1) begin
            str_bytes.push_back({1'b0, cp[6:0]});
        end else begin
            str_bytes.push_back((8'hFF << (8 - len)) |
                                (8'(cp >> (6 * (len - 1))) & (ASCII_MAX >> len)));
            for (int i = int'(len) - 2; i >= 0; i--) begin
                str_bytes.push_back(CONT_TAG | (8'(cp >> (6 * i)) & PAYLOAD6));
            end
        end
    endfunction

    function automatic int unsigned pick_len();
        return ($urandom_range(99) < 75) ? $urandom_range(1, 3)
                                          : $urandom_range(4, MAX_SEQ_BYTES);
    endfunction

    task automatic send_random_string();
        int unsigned tokens;
        int unsigned len;
        int unsigned bits;
        int unsigned roll;
        logic [31:0] mask;
        logic [7:0]  junk;
        str_bytes.delete();
        tokens = $urandom_range(1, 5);
        for (int unsigned t = 0; t < tokens; t++) begin
            roll = $urandom_range(99);
            len  = pick_len();
            if (roll < 60) begin
                bits = (len == 1) ? 7 : 5 * len + 1;
                mask = (bits >= 31) ? 32'h7FFF_FFFF : ((32'h1 << bits) - 1);
                // skew toward short values now and then to hit overlong forms
                if ($urandom_range(3) == 0) mask = mask >> $urandom_range(bits - 1);
                add_char(len, CP_W'($urandom & mask));
            end else if (roll < 72) begin
                str_bytes.push_back(8'($urandom));
            end else if (roll < 82) begin
                len = (len < 2) ? 2 : len;
                add_lead_and_conts(len, $urandom_range(0, len - 2));
            end else if (roll < 92) begin
                len = (len < 2) ? 2 : len;
                add_lead_and_conts(len, $urandom_range(0, len - 2));
                junk = 8'($urandom);
                if ((junk & CONT_MASK) == CONT_TAG) junk = junk ^ 8'h40;
                str_bytes.push_back(junk);
            end else begin
                len = (len < 2) ? 2 : len;
                add_char(len, CP_W'($urandom_range(0, ASCII_MAX)));
            end
        end
        send_string(str_bytes, $urandom_range(9) != 0, $urandom_range(9) != 0);
        random_items += str_bytes.size();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        calm          = 1'b0;
        cycle_count   = 0;
        random_items  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_start_mode(1'b1);
        send_string('{8'h00, 8'h7F}, 1, 1);
        send_string('{8'hC3, 8'hA9}, 1, 1);
        send_string('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF}, 1, 1);
        send_string('{8'hC1, 8'hBF}, 1, 1);                 // overlong to ASCII
        send_string('{8'h80, 8'h41}, 1, 1);                 // stray continuation
        send_string('{8'hFE, 8'hFF}, 1, 1);
        send_string('{8'hE2, 8'h82, 8'h41}, 1, 1);          // bad continuation
        send_string('{8'hF0, 8'h9F}, 1, 1);                 // cut off by end
        send_string('{8'hE2, 8'h82}, 1, 0);
        send_string('{8'h41}, 1, 1);                        // restart mid-sequence
        send_string('{8'hC3}, 1, 1);
        wait_drained();

        // raw start mode
        write_start_mode(1'b0);
        while (random_items < 20) send_random_string();
        wait_drained();

        write_start_mode(1'b1);
        while (random_items < 45) send_random_string();
        wait_drained();
        calm = 1'b1;
        while (random_items < 65) send_random_string();
        calm = 1'b0;
        while (random_items < 85) send_random_string();

        wait_drained();
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/u8d_pkg.sv
design/u8d_front.sv
design/u8d_queue.sv
design/u8d_back.sv
design/utf8_decoder_raw_fallback_core.sv
tb/utf8_decoder_raw_fallback_core_tb.sv
